### design/oale_pkg.sv
// Package: shared constants, types, microcode ROM and dispatch table of the array list engine.
package oale_pkg;

	// Storage geometry
	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths
	localparam int DATA_W = 32;
	localparam int POS_W  = 8;
	localparam int ACT_W  = 3;
	localparam int ST_W   = 2;
	localparam int FIDX_W = 8;
	localparam int ECNT_W = 9;

	typedef enum logic [ACT_W-1:0] {
		A_INSERT     = 3'd0,
		A_ERASE      = 3'd1,
		A_FIND       = 3'd2,
		A_MODIFY     = 3'd3,
		A_PUSH_BACK  = 3'd4,
		A_PUSH_FRONT = 3'd5,
		A_POP_BACK   = 3'd6,
		A_POP_FRONT  = 3'd7
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Microprogram addresses
	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t U_IDLE     = 4'd0;
	localparam upc_t U_DISPATCH = 4'd1;
	localparam upc_t U_INS_INIT = 4'd2;
	localparam upc_t U_INS_LOOP = 4'd3;
	localparam upc_t U_INS_PUT  = 4'd4;
	localparam upc_t U_ERS_INIT = 4'd5;
	localparam upc_t U_ERS_LOOP = 4'd6;
	localparam upc_t U_ERS_DONE = 4'd7;
	localparam upc_t U_FND_INIT = 4'd8;
	localparam upc_t U_FND_LOOP = 4'd9;
	localparam upc_t U_FND_RES  = 4'd10;
	localparam upc_t U_MOD      = 4'd11;
	localparam upc_t U_RESP     = 4'd12;

	// Sequencer controls
	typedef enum logic [1:0] {J_NEXT, J_GOTO, J_WAIT, J_DISPATCH} jmp_t;
	typedef enum logic [1:0] {C_IN, C_END, C_OUT_FREE} cond_t;

	// Datapath controls
	typedef enum logic [2:0] {IX_HOLD, IX_COUNT, IX_POS1, IX_ZERO, IX_STEP} ix_op_t;
	typedef enum logic [1:0] {MD_UP, MD_DN, MD_SCAN} mode_t;
	typedef enum logic [1:0] {WR_NONE, WR_PEND, WR_VALUE} wr_op_t;
	typedef enum logic [1:0] {CN_HOLD, CN_INC, CN_DEC} cnt_op_t;
	typedef enum logic [1:0] {SO_HOLD, SO_CHECK, SO_FIND} st_op_t;

	// One control word of the microprogram
	typedef struct packed {
		jmp_t    jmp;
		cond_t   cond;
		upc_t    target;
		logic    take;
		logic    emit;
		ix_op_t  idx;
		mode_t   mode;
		logic    rd;
		logic    cmp;
		wr_op_t  wr;
		cnt_op_t cnt;
		st_op_t  st;
	} ucw_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic bad;
		logic full;
		logic loop_end;
	} dp_flags_t;

	// Microcode ROM
	function automatic ucw_t ucode(upc_t pc);
		ucw_t w;
		w.jmp    = J_NEXT;
		w.cond   = C_IN;
		w.target = U_IDLE;
		w.take   = 1'b0;
		w.emit   = 1'b0;
		w.idx    = IX_HOLD;
		w.mode   = MD_UP;
		w.rd     = 1'b0;
		w.cmp    = 1'b0;
		w.wr     = WR_NONE;
		w.cnt    = CN_HOLD;
		w.st     = SO_HOLD;
		unique case (pc)
			U_IDLE: begin
				w.take   = 1'b1;
				w.jmp    = J_WAIT;
				w.cond   = C_IN;
				w.target = U_DISPATCH;
			end
			U_DISPATCH: begin
				w.jmp = J_DISPATCH;
				w.st  = SO_CHECK;
			end
			U_INS_INIT: begin
				w.idx = IX_COUNT;
			end
			U_INS_LOOP: begin
				w.jmp    = J_WAIT;
				w.cond   = C_END;
				w.target = U_INS_PUT;
				w.idx    = IX_STEP;
				w.mode   = MD_UP;
				w.rd     = 1'b1;
				w.wr     = WR_PEND;
			end
			U_INS_PUT: begin
				w.jmp    = J_GOTO;
				w.target = U_RESP;
				w.wr     = WR_VALUE;
				w.cnt    = CN_INC;
			end
			U_ERS_INIT: begin
				w.idx = IX_POS1;
			end
			U_ERS_LOOP: begin
				w.jmp    = J_WAIT;
				w.cond   = C_END;
				w.target = U_ERS_DONE;
				w.idx    = IX_STEP;
				w.mode   = MD_DN;
				w.rd     = 1'b1;
				w.wr     = WR_PEND;
			end
			U_ERS_DONE: begin
				w.jmp    = J_GOTO;
				w.target = U_RESP;
				w.cnt    = CN_DEC;
			end
			U_FND_INIT: begin
				w.idx = IX_ZERO;
			end
			U_FND_LOOP: begin
				w.jmp    = J_WAIT;
				w.cond   = C_END;
				w.target = U_FND_RES;
				w.idx    = IX_STEP;
				w.mode   = MD_SCAN;
				w.rd     = 1'b1;
				w.cmp    = 1'b1;
			end
			U_FND_RES: begin
				w.jmp    = J_GOTO;
				w.target = U_RESP;
				w.st     = SO_FIND;
			end
			U_MOD: begin
				w.jmp    = J_GOTO;
				w.target = U_RESP;
				w.wr     = WR_VALUE;
			end
			U_RESP: begin
				w.emit   = 1'b1;
				w.jmp    = J_WAIT;
				w.cond   = C_OUT_FREE;
				w.target = U_IDLE;
			end
			default: begin
				w.jmp    = J_GOTO;
				w.target = U_IDLE;
			end
		endcase
		return w;
	endfunction

	// Entry point of the routine for an action; failed checks go straight to the response
	function automatic upc_t dispatch_target(action_t a, dp_flags_t f);
		upc_t t;
		t = U_RESP;
		if (!f.bad && !f.full) begin
			unique case (a)
				A_INSERT, A_PUSH_BACK, A_PUSH_FRONT: t = U_INS_INIT;
				A_ERASE, A_POP_BACK, A_POP_FRONT:    t = U_ERS_INIT;
				A_FIND:                              t = U_FND_INIT;
				A_MODIFY:                            t = U_MOD;
				default:                             t = U_RESP;
			endcase
		end
		return t;
	endfunction

endpackage

### design/oale_dpath.sv
// Datapath: element store, count, walk index and one-deep read/write pipeline.
module oale_dpath
	import oale_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ucw_t                cw,
	input  logic                take,
	input  action_t             in_action,
	input  logic [POS_W-1:0]    in_position,
	input  logic [DATA_W-1:0]   in_value,
	output dp_flags_t           flags,
	output action_t             act,
	output status_t             status,
	output logic [FIDX_W-1:0]   found_index,
	output logic [ECNT_W-1:0]   element_count
);

	localparam int WIDE_W = CNT_W + POS_W;

	// Element store
	logic [DATA_W-1:0] mem [CAPACITY];

	// Request registers
	action_t           act_q;
	logic [POS_W-1:0]  praw_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  pos_q;

	// State
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_q;
	logic [IDX_W-1:0]  wa_q;
	logic [DATA_W-1:0] rdata_q;
	logic              found_q;
	logic [IDX_W-1:0]  fidx_q;
	status_t           st_q;

	// Combinational
	logic [WIDE_W-1:0] wpos, wcnt;
	logic [CNT_W-1:0]  ep;
	logic              bad_c, full_c;
	logic              in_range, hit, loop_end, rd_en;
	logic [CNT_W-1:0]  idx_m1;
	logic [IDX_W-1:0]  ra, wa_next;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic [IDX_W+FIDX_W-1:0] fidx_ext;
	logic [CNT_W+ECNT_W-1:0] cnt_ext;

	// Request checks and effective position
	always_comb begin
		wpos   = {{CNT_W{1'b0}}, praw_q};
		wcnt   = {{POS_W{1'b0}}, count_q};
		full_c = 1'b0;
		bad_c  = 1'b0;
		ep     = '0;
		unique case (act_q)
			A_INSERT: begin
				ep     = wpos[CNT_W-1:0];
				bad_c  = wpos > wcnt;
				full_c = count_q >= CNT_W'(CAPACITY);
			end
			A_PUSH_BACK: begin
				ep     = count_q;
				full_c = count_q >= CNT_W'(CAPACITY);
			end
			A_PUSH_FRONT: begin
				ep     = '0;
				full_c = count_q >= CNT_W'(CAPACITY);
			end
			A_ERASE, A_MODIFY: begin
				ep    = wpos[CNT_W-1:0];
				bad_c = wpos >= wcnt;
			end
			A_POP_BACK: begin
				ep    = count_q - CNT_W'(1);
				bad_c = count_q == '0;
			end
			A_POP_FRONT: begin
				ep    = '0;
				bad_c = count_q == '0;
			end
			A_FIND: begin
				ep = '0;
			end
			default: begin
				ep = '0;
			end
		endcase
	end

	// Walk control
	always_comb begin
		idx_m1   = idx_q - CNT_W'(1);
		in_range = (cw.mode == MD_UP) ? (idx_q > pos_q) : (idx_q < count_q);
		hit      = pend_q && (rdata_q == val_q);
		loop_end = !in_range || ((cw.mode == MD_SCAN) && (hit || found_q));
		rd_en    = cw.rd && !loop_end;
		if (cw.mode == MD_UP) begin
			ra      = idx_m1[IDX_W-1:0];
			wa_next = idx_q[IDX_W-1:0];
		end else if (cw.mode == MD_DN) begin
			ra      = idx_q[IDX_W-1:0];
			wa_next = idx_m1[IDX_W-1:0];
		end else begin
			ra      = idx_q[IDX_W-1:0];
			wa_next = idx_q[IDX_W-1:0];
		end
	end

	// Write port select
	always_comb begin
		we    = 1'b0;
		waddr = wa_q;
		wdata = rdata_q;
		unique case (cw.wr)
			WR_NONE: we = 1'b0;
			WR_PEND: we = pend_q;
			WR_VALUE: begin
				we    = 1'b1;
				waddr = pos_q[IDX_W-1:0];
				wdata = val_q;
			end
			default: we = 1'b0;
		endcase
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[ra];
		end
	end

	// Request capture and pipeline addresses
	always_ff @(posedge clk) begin
		if (take) begin
			act_q  <= in_action;
			praw_q <= in_position;
			val_q  <= in_value;
		end
		if (cw.st == SO_CHECK) begin
			pos_q <= ep;
		end
		if (rd_en) begin
			wa_q <= wa_next;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			found_q <= 1'b0;
			fidx_q  <= '0;
			st_q    <= ST_OK;
		end else begin
			pend_q <= rd_en;

			unique case (cw.idx)
				IX_HOLD:  idx_q <= idx_q;
				IX_COUNT: idx_q <= count_q;
				IX_POS1:  idx_q <= pos_q + CNT_W'(1);
				IX_ZERO:  idx_q <= '0;
				IX_STEP: begin
					if (rd_en) begin
						idx_q <= (cw.mode == MD_UP) ? idx_m1 : idx_q + CNT_W'(1);
					end
				end
				default:  idx_q <= idx_q;
			endcase

			unique case (cw.cnt)
				CN_HOLD: count_q <= count_q;
				CN_INC:  count_q <= count_q + CNT_W'(1);
				CN_DEC:  count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase

			// First match of a scan
			if (cw.cmp && hit && !found_q) begin
				found_q <= 1'b1;
				fidx_q  <= wa_q;
			end

			unique case (cw.st)
				SO_HOLD: st_q <= st_q;
				SO_CHECK: begin
					found_q <= 1'b0;
					fidx_q  <= '0;
					st_q    <= bad_c ? ST_BADPOS : (full_c ? ST_FULL : ST_OK);
				end
				SO_FIND: st_q <= found_q ? ST_OK : ST_NOTFOUND;
				default: st_q <= st_q;
			endcase
		end
	end

	// Outputs
	assign fidx_ext       = {{FIDX_W{1'b0}}, fidx_q};
	assign cnt_ext        = {{ECNT_W{1'b0}}, count_q};
	assign found_index    = fidx_ext[FIDX_W-1:0];
	assign element_count  = cnt_ext[ECNT_W-1:0];
	assign status         = st_q;
	assign act            = act_q;
	assign flags.bad      = bad_c;
	assign flags.full     = full_c;
	assign flags.loop_end = loop_end;

	// Checks
	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.cnt == CN_INC) |-> (count_q < CNT_W'(CAPACITY)))
		else $error("count grows past capacity");

	a_put_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.wr == WR_VALUE) |-> !pend_q)
		else $error("value write while a shifted word is still pending");

	a_found_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> $past(cw.cmp))
		else $error("match flag set outside a scan");

endmodule

### design/ordered_array_list_engine.sv
// Top level: microcoded sequencer, stream handshakes and result register of the array list engine.
//
//  channel   dir  fields (low bit first)                          accepted when
//  s_axis    in   tuser: action; tdata: position, value            s_axis_tvalid & s_axis_tready
//  m_axis    out  tuser: status; tdata: found_index, element_count m_axis_tvalid & m_axis_tready
//
// One request at a time, walked by a 13-step microprogram over a single-port-write store.
// Modify and failed requests involve no walk; insert shifts the words from the end down to the
// position, erase shifts the words after the position down by one, and find scans from index 0
// to the first match or the end of the list. The walk rate is one store access per cycle through the
// registered read port. Reset empties the list; stored words are not cleared.
// A result waits in the output register while the next request is taken; the sequencer
// holds at its response step only if that register is still occupied.
module ordered_array_list_engine
	import oale_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
	input  logic [2:0]  s_axis_tuser,   // action[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // found_index[7:0], element_count[16:8], zero[23:17]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	upc_t      pc_q, pc_d;
	ucw_t      cw;
	dp_flags_t flags;
	action_t   act;
	status_t   status;
	logic [FIDX_W-1:0] found_index;
	logic [ECNT_W-1:0] element_count;
	logic      take, out_free, cond_ok, emit;

	logic              m_valid_q;
	logic [23:0]       m_data_q;
	logic [ST_W-1:0]   m_user_q;

	// Control word of the current step
	assign cw            = ucode(pc_q);
	assign s_axis_tready = cw.take;
	assign take          = cw.take && s_axis_tvalid;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign emit          = cw.emit && out_free;

	// Branch condition
	always_comb begin
		unique case (cw.cond)
			C_IN:       cond_ok = s_axis_tvalid;
			C_END:      cond_ok = flags.loop_end;
			C_OUT_FREE: cond_ok = out_free;
			default:    cond_ok = 1'b0;
		endcase
	end

	// Next step
	always_comb begin
		unique case (cw.jmp)
			J_NEXT:     pc_d = pc_q + upc_t'(1);
			J_GOTO:     pc_d = cw.target;
			J_WAIT:     pc_d = cond_ok ? cw.target : pc_q;
			J_DISPATCH: pc_d = dispatch_target(act, flags);
			default:    pc_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= U_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	oale_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cw            (cw),
		.take          (take),
		.in_action     (action_t'(s_axis_tuser)),
		.in_position   (s_axis_tdata[7:0]),
		.in_value      (s_axis_tdata[39:8]),
		.flags         (flags),
		.act           (act),
		.status        (status),
		.found_index   (found_index),
		.element_count (element_count)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= {7'd0, element_count, found_index};
			m_user_q <= status;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// Checks
	a_take_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (pc_q == U_DISPATCH))
		else $error("accepted request not dispatched");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (m_axis_tvalid && (pc_q == U_IDLE)))
		else $error("result not presented after response step");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (pc_q == U_IDLE))
		else $error("request taken while a walk is in progress");

endmodule

### tb/tb_ordered_array_list_engine.sv
// Testbench for the array list engine: random and directed list operations, predictor checked.
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
	import oale_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1300;

	typedef enum {GROW, MIXED, SHRINK} trend_t;

	// One expected result transaction
	typedef struct {
		status_t              st;
		logic [FIDX_W-1:0]    idx;
		logic [ECNT_W-1:0]    cnt;
	} list_result_t;

	// Scoreboard: shadow copy of the list and the queue of expected results
	class list_scoreboard;
		logic [DATA_W-1:0] words [CAPACITY];
		int                fill;
		list_result_t      pending [$];
		int                errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		function status_t place(int p, logic [DATA_W-1:0] v);
			if (p > fill)
				return ST_BADPOS;
			if (fill >= CAPACITY)
				return ST_FULL;
			for (int i = fill; i > p; i--)
				words[i] = words[i-1];
			words[p] = v;
			fill++;
			return ST_OK;
		endfunction

		function status_t remove(int p);
			if (p >= fill)
				return ST_BADPOS;
			for (int i = p + 1; i < fill; i++)
				words[i-1] = words[i];
			fill--;
			return ST_OK;
		endfunction

		// Apply an accepted request to the shadow list and queue its result
		function void note_request(action_t act, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
			list_result_t r;
			r.st  = ST_OK;
			r.idx = '0;
			case (act)
				A_INSERT:     r.st = place(int'(pos), val);
				A_ERASE:      r.st = remove(int'(pos));
				A_FIND: begin
					r.st = ST_NOTFOUND;
					for (int i = 0; i < fill; i++) begin
						if (words[i] == val) begin
							r.st  = ST_OK;
							r.idx = i[FIDX_W-1:0];
							break;
						end
					end
				end
				A_MODIFY: begin
					if (int'(pos) < fill)
						words[pos] = val;
					else
						r.st = ST_BADPOS;
				end
				A_PUSH_BACK:  r.st = place(fill, val);
				A_PUSH_FRONT: r.st = place(0, val);
				A_POP_BACK:   r.st = (fill == 0) ? ST_BADPOS : remove(fill - 1);
				default:      r.st = remove(0);
			endcase
			r.cnt = fill[ECNT_W-1:0];
			pending.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("ERROR at %0t: %s", $time, what);
			errors++;
		endtask

		// Compare one accepted result with the oldest expectation
		task check_result(logic [ST_W-1:0] st, logic [FIDX_W-1:0] idx, logic [ECNT_W-1:0] cnt);
			list_result_t e;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d index=%0d count=%0d",
					st, idx, cnt));
				return;
			end
			e = pending.pop_front();
			if (st !== e.st)
				report_mismatch($sformatf("status %0d, expected %0d", st, e.st));
			if (idx !== e.idx)
				report_mismatch($sformatf("found_index %0d, expected %0d", idx, e.idx));
			if (cnt !== e.cnt)
				report_mismatch($sformatf("element_count %0d, expected %0d", cnt, e.cnt));
		endtask
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;   // position[7:0], value[39:8]
	logic [2:0]  s_axis_tuser  = '0;   // action[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // found_index[7:0], element_count[16:8], zero[23:17]
	logic [1:0]  m_axis_tuser;         // status[1:0]

	list_scoreboard board;
	int             cycles    = 0;
	int             src_calm  = 0;
	int             snk_calm  = 0;

	ordered_array_list_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Wait before a transaction: drawn at random, with occasional runs of back-to-back traffic
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	// Drive one request transaction and record it once accepted
	task automatic send_request(action_t act, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		int gap;
		gap = draw_wait(src_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, pos};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(act, pos, val);
	endtask

	// Random request biased toward growing, shrinking or churning the list
	task automatic random_request(trend_t trend);
		int                grow_pct;
		int                shrink_pct;
		int                roll;
		int                n;
		action_t           act;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		n = board.fill;
		case (trend)
			GROW:    begin grow_pct = 85; shrink_pct = 5;  end
			SHRINK:  begin grow_pct = 5;  shrink_pct = 85; end
			default: begin grow_pct = 35; shrink_pct = 35; end
		endcase
		// small pool gives duplicates, so find must report the first match
		case ($urandom_range(0, 3))
			0:       val = $urandom_range(0, 7);
			1:       val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: val = $urandom();
		endcase
		roll = $urandom_range(0, 99);
		if (roll < grow_pct) begin
			case ($urandom_range(0, 2))
				0:       act = A_INSERT;
				1:       act = A_PUSH_BACK;
				default: act = A_PUSH_FRONT;
			endcase
		end else if (roll < grow_pct + shrink_pct) begin
			case ($urandom_range(0, 2))
				0:       act = A_ERASE;
				1:       act = A_POP_BACK;
				default: act = A_POP_FRONT;
			endcase
		end else if ($urandom_range(0, 1) == 1) begin
			act = A_FIND;
		end else begin
			act = A_MODIFY;
		end
		// mostly legal positions, some anywhere in range
		if ($urandom_range(0, 9) == 0)
			pos = POS_W'($urandom_range(0, 255));
		else if (act == A_INSERT)
			pos = POS_W'($urandom_range(0, (n > 255) ? 255 : n));
		else
			pos = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
		if (act == A_FIND && n > 0 && $urandom_range(0, 9) < 7)
			val = board.words[$urandom_range(0, n - 1)];
		send_request(act, pos, val);
	endtask

	// Result side: random stalls, every accepted transaction is checked
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(snk_calm);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8]);
		end
	end

	// Main sequence
	initial begin
		trend_t trend;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// failures on an empty list
		send_request(A_INSERT,     8'd1,   32'h0000_0005);
		send_request(A_POP_BACK,   8'd0,   32'h0);
		send_request(A_POP_FRONT,  8'd0,   32'h0);
		send_request(A_ERASE,      8'd0,   32'h0);
		send_request(A_MODIFY,     8'd0,   32'h1);
		send_request(A_FIND,       8'd0,   32'h0);
		// build a short list with extreme values
		send_request(A_PUSH_BACK,  8'd0,   32'h7FFF_FFFF);
		send_request(A_PUSH_FRONT, 8'd0,   32'h8000_0000);
		send_request(A_INSERT,     8'd2,   32'hFFFF_FFFF);
		send_request(A_INSERT,     8'd1,   32'h0000_0000);
		send_request(A_INSERT,     8'd255, 32'h1);
		send_request(A_FIND,       8'd0,   32'hFFFF_FFFF);
		send_request(A_FIND,       8'd0,   32'h1234_5678);
		send_request(A_MODIFY,     8'd3,   32'h1234_5678);
		send_request(A_MODIFY,     8'd4,   32'h1);
		send_request(A_ERASE,      8'd4,   32'h0);
		send_request(A_ERASE,      8'd1,   32'h0);
		send_request(A_FIND,       8'd0,   32'h1234_5678);
		send_request(A_POP_BACK,   8'd0,   32'h0);
		send_request(A_POP_FRONT,  8'd0,   32'h0);
		send_request(A_INSERT,     8'd0,   32'hA5A5_A5A5);
		send_request(A_ERASE,      8'd255, 32'h0);
		send_request(A_PUSH_BACK,  8'd0,   32'h5A5A_5A5A);
		send_request(A_FIND,       8'd0,   32'h5A5A_5A5A);

		// fill to capacity, churn, drain to empty, churn, fill again
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k < 340)
				trend = GROW;
			else if (k < 560)
				trend = MIXED;
			else if (k < 880)
				trend = SHRINK;
			else if (k < 1000)
				trend = MIXED;
			else
				trend = GROW;
			random_request(trend);
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
